FILE: hdl/sba_pkg.sv
package sba_pkg;

    localparam int CLS_W   = 4;
    localparam int SIZE_W  = 16;
    localparam int SLOT_W  = 13;
    localparam int OFS_W   = 16;
    localparam int STAT_W  = 2;
    localparam int STAMP_W = 32;
    localparam int CAP_W   = 17;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERSIZE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_FREE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic op;
        logic [SIZE_W-1:0] req_size;
        logic [3:0] free_slab;
        logic [SLOT_W-1:0] free_slot;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [3:0] slab_index;
        logic [SLOT_W-1:0] slot_index;
        logic [CLS_W-1:0] size_class;
        logic [OFS_W-1:0] byte_offset;
        logic slab_released;
    } rsp_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture request, start
        logic class_step; // one class-size compare step, starts the divider on the final class
        logic div_step;
        logic scan_slab;  // inspect one slab for eligibility
        logic word_rd;    // issue bitmap word read
        logic word_chk;   // look at read data
        logic clr_step;   // clear one bitmap word on claim
        logic claim;
        logic commit;     // write slot bit, counters, build result
        logic fail;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_free;
        logic oversize;
        logic class_done;
        logic div_done;
        logic cap_zero;
        logic slab_last;
        logic slab_ok;    // scanned slab is live, of the class, not full
        logic have_best;
        logic have_free_slab;
        logic word_hit;
        logic word_end;
        logic clr_done;
        logic free_ok;
    } sts_t;

endpackage

FILE: hdl/sba_if.sv
interface sba_req_if;
    logic valid;
    logic ready;
    sba_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sba_rsp_if;
    logic valid;
    logic ready;
    sba_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/sba_datapath.sv
module sba_datapath #(
    parameter int POOL_SLABS = 16,
    parameter int NUM_CLASSES = 12,
    parameter int MAX_SLOTS = 6000,
    parameter int SLAB_BYTES = 65536
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [15:0] header_bytes,
    input  sba_pkg::req_t req,
    input  sba_pkg::cmd_t cmd,
    output sba_pkg::sts_t sts,
    output sba_pkg::rsp_t rsp
);
    import sba_pkg::*;

    localparam int SLAB_W = (POOL_SLABS > 1) ? $clog2(POOL_SLABS) : 1;
    localparam int BM_WORDS = (MAX_SLOTS + 63) / 64;
    localparam int WORD_W = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
    localparam int WCNT_W = $clog2(BM_WORDS + 1);
    localparam int DEPTH = POOL_SLABS * BM_WORDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_SLOTS);
    localparam logic [CAP_W-1:0] SLAB_SZ = CAP_W'(SLAB_BYTES);

    // per-slab state
    logic [POOL_SLABS-1:0] in_use_reg;
    logic [CLS_W-1:0] cls_reg [POOL_SLABS];
    logic [SLOT_W-1:0] fcnt_reg [POOL_SLABS];
    logic [STAMP_W-1:0] stamp_reg [POOL_SLABS];
    logic [STAMP_W-1:0] stamp_ctr_reg;

    // bitmap memory, one word per slab and word index
    logic [63:0] bm_mem [DEPTH];
    logic [63:0] rd_data_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [63:0] wr_data;
    logic wr_en;

    // request and working registers
    req_t req_reg;
    logic [CLS_W-1:0] cls_r;
    logic [CAP_W-1:0] rem_reg;    // partial remainder
    logic [CAP_W-1:0] quo_reg;
    logic [4:0] div_cnt_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [SLAB_W:0] scan_reg;    // slab pointer, one extra bit for end
    logic [SLAB_W-1:0] best_reg;
    logic best_ok_reg;
    logic [STAMP_W-1:0] best_age_reg;
    logic [WCNT_W-1:0] word_reg;
    rsp_t rsp_reg;

    logic [SLAB_W-1:0] scan_idx;
    logic scanning;
    logic [SLAB_W-1:0] tgt_slab;
    logic [CAP_W-1:0] elem;
    logic [CAP_W+5:0] base;
    logic [63:0] inv;
    logic [6:0] lim;
    logic [5:0] low_bit;
    logic found;
    logic [SLAB_W-1:0] first_free;
    logic any_free;
    logic [CAP_W:0] div_try;
    logic [STAMP_W-1:0] age;
    logic [SLAB_W-1:0] fs;
    logic fs_range;
    logic [CAP_W-1:0] fcnt1;
    logic slab_ok;
    logic upd_best;
    rsp_t fail_rsp;

    assign scan_idx = scan_reg[SLAB_W-1:0];
    assign scanning = (scan_reg != (SLAB_W+1)'(POOL_SLABS));
    assign elem = (CAP_W'(4) << cls_r) + CAP_W'(8);
    assign fs = SLAB_W'(req_reg.free_slab);
    assign fs_range = ({28'd0, req_reg.free_slab} < POOL_SLABS);
    // freed slab on a free; scanned slab during the scan, chosen slab after it
    assign tgt_slab = req_reg.op ? fs : (scanning ? scan_idx : best_reg);
    assign base = (CAP_W+6)'(word_reg) << 6;
    assign slab_ok = in_use_reg[scan_idx] && cls_reg[scan_idx] == cls_r
        && fcnt_reg[scan_idx] != '0;

    // mask read word to capacity, find lowest clear bit
    always_comb
    begin
        inv = ~rd_data_reg;
        lim = 7'd64;
        if ((CAP_W+6)'(cap_reg) < base + (CAP_W+6)'(64))
            lim = 7'((CAP_W+6)'(cap_reg) - base);
        if (lim < 7'd64)
            inv = inv & ((64'd1 << lim[5:0]) - 64'd1);
        found = 1'b0;
        low_bit = '0;
        for (int b = 63; b >= 0; b--)
        begin
            if (inv[b])
            begin
                found = 1'b1;
                low_bit = 6'(b);
            end
        end
    end

    // lowest unused slab
    always_comb
    begin
        any_free = 1'b0;
        first_free = '0;
        for (int s = POOL_SLABS - 1; s >= 0; s--)
        begin
            if (!in_use_reg[s])
            begin
                any_free = 1'b1;
                first_free = SLAB_W'(s);
            end
        end
    end

    assign div_try = {rem_reg, 1'b0} - {1'b0, elem};
    assign age = stamp_ctr_reg - stamp_reg[scan_idx];
    assign fcnt1 = CAP_W'(fcnt_reg[fs]) + CAP_W'(1);

    // status toward controller
    always_comb
    begin
        sts = '0;
        sts.is_free = req_reg.op;
        sts.oversize = (cls_r == CLS_W'(NUM_CLASSES - 1))
            && ({1'b0, req_reg.req_size} > (17'd4 << cls_r));
        sts.class_done = ({1'b0, req_reg.req_size} <= (17'd4 << cls_r))
            || (cls_r == CLS_W'(NUM_CLASSES - 1));
        sts.div_done = (div_cnt_reg == 5'd0);
        sts.cap_zero = (cap_reg == '0);
        sts.slab_last = !scanning;
        sts.slab_ok = slab_ok;
        sts.have_best = best_ok_reg;
        sts.have_free_slab = any_free;
        sts.word_hit = found && ((CAP_W+6)'(cap_reg) > base);
        sts.word_end = ((CAP_W+6)'(cap_reg) <= base + (CAP_W+6)'(64))
            || (word_reg == WCNT_W'(BM_WORDS - 1));
        sts.clr_done = (word_reg == WCNT_W'(BM_WORDS - 1));
        sts.free_ok = fs_range && in_use_reg[fs]
            && ({4'd0, req_reg.free_slot} < cap_reg)
            && rd_data_reg[req_reg.free_slot[5:0]];
    end

    // bitmap write port
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = ADDR_W'(tgt_slab) * ADDR_W'(BM_WORDS) + ADDR_W'(word_reg);
        wr_data = rd_data_reg;
        if (cmd.clr_step)
        begin
            wr_en = 1'b1;
            wr_data = '0;
        end
        else if (cmd.commit && !req_reg.op)
        begin
            wr_en = 1'b1;
            wr_data = rd_data_reg | (64'd1 << low_bit);
        end
        else if (cmd.commit && req_reg.op && (fcnt1 < cap_reg))
        begin
            wr_en = 1'b1;
            wr_data = rd_data_reg & ~(64'd1 << req_reg.free_slot[5:0]);
        end
    end

    // bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            bm_mem[wr_addr] <= wr_data;
        if (cmd.word_rd)
            rd_data_reg <= bm_mem[ADDR_W'(tgt_slab) * ADDR_W'(BM_WORDS)
                + ADDR_W'(word_reg)];
    end

    // candidate slab in scan: keep the oldest, lowest index on a tie
    assign upd_best = cmd.word_chk && sts.word_hit && scanning
        && (!best_ok_reg || age > best_age_reg);

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            cls_r <= '0;
            best_ok_reg <= 1'b0;
            scan_reg <= '0;
            word_reg <= '0;
        end
        if (cmd.class_step)
        begin
            if (req_reg.op)
                cls_r <= cls_reg[fs];
            else if (!sts.class_done)
                cls_r <= cls_r + CLS_W'(1);
            if (req_reg.op || sts.class_done)
            begin
                // start divider on final class, or with the slab's class on a free
                rem_reg <= '0;
                quo_reg <= (header_bytes >= SLAB_BYTES) ? '0
                    : SLAB_SZ - CAP_W'(header_bytes);
                div_cnt_reg <= 5'(CAP_W);
            end
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit a cycle
            if (!div_try[CAP_W])
            begin
                rem_reg <= div_try[CAP_W-1:0] | CAP_W'(quo_reg[CAP_W-1]);
                quo_reg <= {quo_reg[CAP_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[CAP_W-2:0], quo_reg[CAP_W-1]};
                quo_reg <= {quo_reg[CAP_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 5'd1;
            // a free reads the word that holds its slot
            word_reg <= req_reg.op ? WCNT_W'(req_reg.free_slot[SLOT_W-1:6]) : '0;
        end
        if (cmd.word_chk)
        begin
            if (sts.word_hit || sts.word_end)
            begin
                scan_reg <= scan_reg + (SLAB_W+1)'(1);
                word_reg <= '0;
            end
            else
                word_reg <= word_reg + WCNT_W'(1);
        end
        if (cmd.scan_slab)
        begin
            word_reg <= '0;
            if (!slab_ok)
                scan_reg <= scan_reg + (SLAB_W+1)'(1);
        end
        if (upd_best)
        begin
            best_reg <= scan_idx;
            best_age_reg <= age;
            best_ok_reg <= 1'b1;
        end
        else if (cmd.claim)
        begin
            best_reg <= first_free;
            best_ok_reg <= 1'b1;
            word_reg <= '0;
        end
        if (cmd.clr_step && !sts.clr_done)
            word_reg <= word_reg + WCNT_W'(1);
        if (cmd.clr_step && sts.clr_done)
            word_reg <= '0;
    end

    // capacity captured once divider finishes
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && div_cnt_reg == 5'd1)
            cap_reg <= ({quo_reg[CAP_W-2:0], ~div_try[CAP_W]} > MAX_CAP)
                ? MAX_CAP : {quo_reg[CAP_W-2:0], ~div_try[CAP_W]};
        if (cmd.load)
            cap_reg <= '0;
    end

    // offset of the chosen slot
    logic [SLOT_W-1:0] out_slot;
    logic [31:0] prod;
    assign out_slot = req_reg.op ? req_reg.free_slot : (SLOT_W'(base) | SLOT_W'(low_bit));
    assign prod = 32'(out_slot) * 32'(elem);

    // error result
    always_comb
    begin
        fail_rsp = '0;
        if (req_reg.op)
            fail_rsp.status = ST_BAD_FREE;
        else if (sts.oversize)
            fail_rsp.status = ST_OVERSIZE;
        else
        begin
            fail_rsp.status = ST_EXHAUSTED;
            fail_rsp.size_class = cls_r;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.fail)
            rsp_reg <= fail_rsp;
        else if (cmd.commit)
        begin
            rsp_reg.status <= ST_OK;
            rsp_reg.slab_index <= 4'(tgt_slab);
            rsp_reg.slot_index <= out_slot;
            rsp_reg.size_class <= cls_r;
            rsp_reg.byte_offset <= OFS_W'(32'(header_bytes) + prod + 32'd8);
            rsp_reg.slab_released <= req_reg.op && (fcnt1 >= cap_reg);
        end
    end
    assign rsp = rsp_reg;

    // per-slab state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            stamp_ctr_reg <= '0;
            for (int s = 0; s < POOL_SLABS; s++)
            begin
                cls_reg[s] <= '0;
                stamp_reg[s] <= '0;
            end
        end
        else
        begin
            if (cmd.claim)
            begin
                in_use_reg[first_free] <= 1'b1;
                cls_reg[first_free] <= cls_r;
                stamp_reg[first_free] <= stamp_ctr_reg;
                stamp_ctr_reg <= stamp_ctr_reg + STAMP_W'(1);
            end
            if (cmd.commit && req_reg.op && (fcnt1 >= cap_reg))
                in_use_reg[fs] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
            fcnt_reg[first_free] <= SLOT_W'(cap_reg);
        else if (cmd.commit && !req_reg.op)
            fcnt_reg[best_reg] <= fcnt_reg[best_reg] - SLOT_W'(1);
        else if (cmd.commit && req_reg.op && (fcnt1 < cap_reg))
            fcnt_reg[fs] <= SLOT_W'(fcnt1);
    end

endmodule

FILE: hdl/sba_ctrl.sv
module sba_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sba_pkg::sts_t sts,
    output sba_pkg::cmd_t cmd
);
    import sba_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_PICK  = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_FRD   = 4'd8;
    localparam logic [3:0] S_FCHK  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_WAIT  = 4'd11;
    localparam logic [3:0] S_ARD   = 4'd12;
    localparam logic [3:0] S_ACHK  = 4'd13;
    localparam logic [3:0] S_FDIV  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic ov_reg, ov_next;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CLASS;
                end
            end
            // walk classes; free uses the slab's class, handled in datapath by op
            S_CLASS:
            begin
                cmd.class_step = 1'b1;
                if (sts.is_free)
                    state_next = S_FDIV;
                else if (sts.oversize)
                begin
                    cmd.fail = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.class_done)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_step = 1'b0;
                    if (sts.cap_zero)
                    begin
                        cmd.fail = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_SCAN;
                end
            end
            S_FDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next = S_FRD;
                end
            end
            // skip slabs that cannot serve the class, read words of the rest
            S_SCAN:
            begin
                if (sts.slab_last)
                    state_next = S_PICK;
                else
                begin
                    cmd.scan_slab = 1'b1;
                    if (sts.slab_ok)
                        state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.word_rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.word_chk = 1'b1;
                if (sts.word_hit || sts.word_end)
                    state_next = S_SCAN;
                else
                    state_next = S_RD;
            end
            S_PICK:
            begin
                if (sts.have_best)
                    state_next = S_ARD;
                else if (sts.have_free_slab)
                begin
                    cmd.claim = 1'b1;
                    state_next = S_CLR;
                end
                else
                begin
                    cmd.fail = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = S_ARD;
            end
            S_ARD:
            begin
                cmd.word_rd = 1'b1;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (sts.word_hit)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.word_end)
                begin
                    cmd.fail = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.word_chk = 1'b1;
                    state_next = S_ARD;
                end
            end
            S_FRD:
            begin
                cmd.word_rd = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (sts.free_ok)
                    cmd.commit = 1'b1;
                else
                    cmd.fail = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ov_next = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!ov_reg)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

endmodule

FILE: hdl/slab_bitmap_allocator.sv
// channel   dir   payload
// req       in    op, req_size, free_slab, free_slot
// rsp       out   status, slab_index, slot_index, size_class, byte_offset, slab_released
// cfg       in    header_bytes (write enable, 16-bit data)
//
// one request at a time; an allocation walks the size classes, runs the bit-serial
// capacity divider, scans the pool slabs and reads the bitmap words of each live slab
// of the class, reads the words of the chosen slab again, and first clears a fresh
// slab word by word when one is claimed; a free runs the divider and reads the
// bitmap word that holds its slot.
// reset clears slab control state; the bitmap is cleared word by word on claim.
// a held result blocks the next request until taken.
module slab_bitmap_allocator #(
    parameter int POOL_SLABS = 16,
    parameter int NUM_CLASSES = 12,
    parameter int MAX_SLOTS = 6000,
    parameter int SLAB_BYTES = 65536
) (
    input  logic clk,
    input  logic rst_n,
    sba_req_if.sink req,
    sba_rsp_if.source rsp,
    input  logic cfg_we,
    input  logic [15:0] cfg_wdata
);
    import sba_pkg::*;

    logic [15:0] header_reg;
    cmd_t cmd;
    sts_t sts;
    rsp_t rsp_data;

    // header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= 16'd784;
        else if (cfg_we)
            header_reg <= cfg_wdata;
    end

    sba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .sts(sts), .cmd(cmd)
    );

    sba_datapath #(
        .POOL_SLABS(POOL_SLABS), .NUM_CLASSES(NUM_CLASSES),
        .MAX_SLOTS(MAX_SLOTS), .SLAB_BYTES(SLAB_BYTES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .header_bytes(header_reg),
        .req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp_data)
    );

    assign rsp.data = rsp_data;

endmodule

FILE: hdl/sba_checker.sv
module sba_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [1:0] rsp_status,
    input logic [3:0] rsp_class,
    input logic rsp_released
);
    // result stays up until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped");
    // no new request while a result waits
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("accepted while result pending");
    // released only on ok
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_released |-> rsp_status == 2'd0)
        else $error("release on error");
    // class range
    a_cls: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_class < 4'd12)
        else $error("bad class");
endmodule

bind slab_bitmap_allocator sba_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.data.status), .rsp_class(rsp.data.size_class),
    .rsp_released(rsp.data.slab_released)
);
